// ----- sv/hse_pkg.sv -----
// Package: shared types, constants and the quarter-wave sine table.
`default_nettype none
package hse_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int FULL_TURN = 4 * SINE_TABLE_DEPTH;
  localparam int PW = $clog2(FULL_TURN);
  localparam int TW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_INV_SPAN = 2'd1;
  localparam logic [1:0] REG_HARM_COUNT = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TMUL, ST_TSAT, ST_DMUL, ST_DACC,
    ST_HADDR, ST_HMC, ST_HMS, ST_HACC, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_START, DP_TMUL, DP_TSAT, DP_DMUL, DP_DACC,
    DP_HADDR, DP_HMC, DP_HMS, DP_HACC, DP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic multi;
    logic j_last;
    logic out_free;
  } status_t;

  typedef logic [14:0] qtab_t [0:SINE_TABLE_DEPTH];

  function automatic qtab_t build_qtab();
    qtab_t tbl;
    logic [63:0] ang;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      ang = HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH;
      x2 = (ang * ang) >> 30;
      term = ang;
      sum = ang;
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          6: term = term / 64'd156;
          7: term = term / 64'd210;
          8: term = term / 64'd272;
          9: term = term / 64'd342;
          default: term = term / 64'd420;
        endcase
        if (n % 2 == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + 64'd16384) >> 15;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      tbl[k] = r[14:0];
    end
    return tbl;
  endfunction

endpackage
`default_nettype wire

// ----- sv/hse_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/hse_ctrl.sv -----
// Controller: sequences normalization, drift and one harmonic at a time.
`default_nettype none
module hse_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             kind,
  input  wire hse_pkg::status_t sts,
  output hse_pkg::cmd_t         cmd
);
  import hse_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op = DP_NOP;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (kind == KIND_EVAL) begin
            cmd.op = DP_START;
            state_next = ST_TMUL;
          end else begin
            cmd.op = DP_LOAD;
          end
        end
      end
      ST_TMUL: begin
        cmd.op = DP_TMUL;
        state_next = ST_TSAT;
      end
      ST_TSAT: begin
        cmd.op = DP_TSAT;
        state_next = ST_DMUL;
      end
      ST_DMUL: begin
        cmd.op = DP_DMUL;
        state_next = ST_DACC;
      end
      ST_DACC: begin
        cmd.op = DP_DACC;
        state_next = sts.multi ? ST_HADDR : ST_FIN;
      end
      ST_HADDR: begin
        cmd.op = DP_HADDR;
        state_next = ST_HMC;
      end
      ST_HMC: begin
        cmd.op = DP_HMC;
        state_next = ST_HMS;
      end
      ST_HMS: begin
        cmd.op = DP_HMS;
        state_next = ST_HACC;
      end
      ST_HACC: begin
        cmd.op = DP_HACC;
        state_next = sts.j_last ? ST_FIN : ST_HADDR;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.op = DP_FIN;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/hse_dp.sv -----
// Datapath: config registers, coefficient store, shared multiplier, accumulator.
`default_nettype none
module hse_dp #(
  parameter int MAX_HARMONICS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [4:0]         coeff_index,
  input  wire logic signed [31:0] coeff_value,
  input  wire logic signed [31:0] x_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      series_value,
  output logic                    saturated,
  input  wire hse_pkg::cmd_t      cmd,
  output hse_pkg::status_t        sts
);
  import hse_pkg::*;

  localparam int DEPTH = 2 * MAX_HARMONICS;
  localparam int AW = $clog2(DEPTH);
  localparam int HW = $clog2(MAX_HARMONICS + 1);
  localparam qtab_t QTAB = build_qtab();

  logic signed [31:0] x_min;
  logic        [31:0] inv_span;
  logic        [4:0]  harm_count;

  logic signed [32:0] diff;
  logic signed [66:0] preg;
  logic signed [66:0] hprod;
  logic signed [63:0] acc;
  logic signed [31:0] t;
  logic        [23:0] phase;
  logic        [HW-1:0] j;
  logic signed [16:0] sin_v;
  logic signed [16:0] cos_v;
  logic               sat;

  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;
  logic               ram_we;

  logic [HW-1:0]      hc_eff;
  logic [32:0]        mag;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_p;
  logic [42:0]        tm;
  logic signed [31:0] t_new;
  logic               t_clip;
  logic [24+PW-1:0]   pfull;
  logic [PW-1:0]      p_sin;
  logic [PW-1:0]      p_cos;
  logic [TW-1:0]      idx_sin;
  logic [TW-1:0]      idx_cos;
  logic signed [67:0] hsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= '0;
      inv_span <= 32'd16777216;
      harm_count <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_MIN: x_min <= cfg_data;
        REG_INV_SPAN: inv_span <= cfg_data;
        REG_HARM_COUNT: harm_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign ram_we = (cmd.op == DP_LOAD) && (32'(coeff_index) < DEPTH);

  always_comb begin
    case (cmd.op) inside
      DP_TMUL, DP_TSAT, DP_DMUL: raddr = AW'(1);
      DP_HADDR: raddr = AW'({j, 1'b0});
      DP_HMC: raddr = AW'({j, 1'b1});
      default: raddr = '0;
    endcase
  end

  hse_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk(clk),
    .we(ram_we),
    .waddr(AW'(coeff_index)),
    .wdata(coeff_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    if (harm_count == 5'd0) begin
      hc_eff = HW'(1);
    end else if (32'(harm_count) > MAX_HARMONICS) begin
      hc_eff = HW'(MAX_HARMONICS);
    end else begin
      hc_eff = HW'(harm_count);
    end
  end

  assign sts.multi = hc_eff > HW'(1);
  assign sts.j_last = (j + HW'(1)) == hc_eff;
  assign sts.out_free = !out_valid || out_ready;

  assign mag = diff[32] ? 33'(-diff) : 33'(diff);

  always_comb begin
    case (cmd.op)
      DP_TMUL: begin
        mul_a = {1'b0, mag};
        mul_b = {1'b0, inv_span};
      end
      DP_DMUL: begin
        mul_a = 34'(t);
        mul_b = 33'(signed'(rdata));
      end
      DP_HMC: begin
        mul_a = 34'(cos_v);
        mul_b = 33'(signed'(rdata));
      end
      default: begin
        mul_a = 34'(sin_v);
        mul_b = 33'(signed'(rdata));
      end
    endcase
  end

  assign mul_p = 67'(mul_a) * 67'(mul_b);

  assign tm = preg[66:24];
  always_comb begin
    t_clip = 1'b0;
    if (!diff[32] && tm > 43'd2147483647) begin
      t_new = 32'sh7FFFFFFF;
      t_clip = 1'b1;
    end else if (diff[32] && tm > 43'd2147483648) begin
      t_new = 32'sh80000000;
      t_clip = 1'b1;
    end else if (diff[32]) begin
      t_new = 32'(-tm);
    end else begin
      t_new = 32'(tm);
    end
  end

  assign pfull = (24+PW)'(phase) * (24+PW)'(FULL_TURN);
  assign p_sin = pfull[24+PW-1:24];
  assign p_cos = p_sin + PW'(SINE_TABLE_DEPTH);
  assign idx_sin = p_sin[PW-2] ? TW'(SINE_TABLE_DEPTH - 32'(p_sin % SINE_TABLE_DEPTH))
                               : TW'(p_sin % SINE_TABLE_DEPTH);
  assign idx_cos = p_cos[PW-2] ? TW'(SINE_TABLE_DEPTH - 32'(p_cos % SINE_TABLE_DEPTH))
                               : TW'(p_cos % SINE_TABLE_DEPTH);

  assign hsum = 68'(hprod) + 68'(preg);

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_START: begin
        diff <= 33'(x_value) - 33'(x_min);
        sat <= 1'b0;
      end
      DP_TMUL: begin
        preg <= mul_p;
        acc <= 64'(signed'(rdata));
      end
      DP_TSAT: begin
        t <= t_new;
        phase <= t_new[23:0];
        sat <= t_clip;
      end
      DP_DMUL: preg <= mul_p;
      DP_DACC: begin
        acc <= acc + 64'(preg >>> 24);
        j <= HW'(1);
      end
      DP_HADDR: begin
        sin_v <= p_sin[PW-1] ? -17'(QTAB[idx_sin]) : 17'(QTAB[idx_sin]);
        cos_v <= p_cos[PW-1] ? -17'(QTAB[idx_cos]) : 17'(QTAB[idx_cos]);
      end
      DP_HMC: preg <= mul_p;
      DP_HMS: begin
        hprod <= preg;
        preg <= mul_p;
      end
      DP_HACC: begin
        acc <= acc + 64'(hsum >>> 15);
        j <= j + HW'(1);
        phase <= phase + t[23:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == DP_FIN) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_FIN) begin
      if (acc > 64'sd2147483647) begin
        series_value <= 32'sh7FFFFFFF;
        saturated <= 1'b1;
      end else if (acc < -64'sd2147483648) begin
        series_value <= 32'sh80000000;
        saturated <= 1'b1;
      end else begin
        series_value <= acc[31:0];
        saturated <= sat;
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/harmonic_series_eval_unit.sv -----
// Top level: offset, drift and truncated Fourier series evaluator.
// A load beat writes one coefficient slot, and the unit stays ready for the next beat.
// An evaluate beat runs TMUL, TSAT, DMUL and DACC, then HADDR, HMC, HMS and HACC
// for each harmonic after the first, H the effective harmonic count, then FIN, which waits
// for a free output register; one shared multiplier runs two products per harmonic. No new beat is taken until then.
// Synchronous reset restores the state, config registers and out_valid; the coefficient store is not cleared.
`default_nettype none
module harmonic_series_eval_unit #(
  parameter int MAX_HARMONICS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [4:0]         coeff_index,
  input  wire logic signed [31:0] coeff_value,
  input  wire logic signed [31:0] x_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      series_value,
  output logic                    saturated
);
  import hse_pkg::*;

  cmd_t    cmd;
  status_t sts;

  hse_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .sts(sts),
    .cmd(cmd)
  );

  hse_dp #(.MAX_HARMONICS(MAX_HARMONICS)) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .coeff_index(coeff_index),
    .coeff_value(coeff_value),
    .x_value(x_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .series_value(series_value),
    .saturated(saturated),
    .cmd(cmd),
    .sts(sts)
  );
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for harmonic_series_eval_unit: predicts each series evaluation and checks every result beat.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import hse_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [4:0] coeff_index = '0;
  logic signed [31:0] coeff_value = '0;
  logic signed [31:0] x_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] series_value;
  logic saturated;

  harmonic_series_eval_unit dut (.*);

  always #1 clk = ~clk;

  typedef struct {
    logic signed [31:0] val;
    logic sat;
  } series_res_t;

  series_res_t series_q[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  logic [14:0] qtab [0:1024];
  logic signed [31:0] m_xmin;
  logic [31:0] m_span;
  logic [4:0] m_hc;
  logic signed [31:0] m_coef [0:31];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sine_of(int p);
    int q;
    int r;
    q = (p / 1024) & 3;
    r = p % 1024;
    case (q)
      0: return longint'(qtab[r]);
      1: return longint'(qtab[1024 - r]);
      2: return -longint'(qtab[r]);
      default: return -longint'(qtab[1024 - r]);
    endcase
  endfunction

  function automatic series_res_t eval_series(logic signed [31:0] x);
    series_res_t r;
    longint diff;
    longint acc;
    longint t;
    logic [63:0] mag;
    logic [95:0] prod;
    logic [63:0] tm;
    logic [31:0] tb;
    logic [31:0] ph;
    int hc;
    int p;
    bit neg;
    r.sat = 1'b0;
    diff = longint'(x) - longint'(m_xmin);
    neg = diff < 0;
    mag = neg ? -diff : diff;
    prod = {32'd0, mag} * {64'd0, m_span};
    tm = prod[87:24];
    if (!neg && tm > 64'd2147483647) begin
      tm = 64'd2147483647; r.sat = 1'b1;
    end else if (neg && tm > 64'd2147483648) begin
      tm = 64'd2147483648; r.sat = 1'b1;
    end
    t = neg ? -longint'(tm) : longint'(tm);
    hc = int'(m_hc);
    if (hc > 16) hc = 16;
    acc = longint'(m_coef[0]) + fshift(t * longint'(m_coef[1]), 24);
    tb = t[31:0];
    for (int j = 1; j < hc; j++) begin
      ph = (tb * j) & 32'hFFFFFF;
      p = int'((64'(ph) * 4096) >> 24);
      acc += fshift(sine_of((p + 1024) % 4096) * longint'(m_coef[2*j])
                  + sine_of(p) * longint'(m_coef[2*j+1]), 15);
    end
    if (acc > 64'sd2147483647) begin
      acc = 2147483647; r.sat = 1'b1;
    end else if (acc < -64'sd2147483648) begin
      acc = -2147483648; r.sat = 1'b1;
    end
    r.val = acc[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("harmonic_series_eval_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    series_res_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (series_q.size() == 0) begin
          $error("unexpected result beat series_value=%0d", series_value);
          errors++;
        end else begin
          e = series_q.pop_front();
          if (series_value !== e.val) begin
            $error("series_value expected %0d actual %0d", e.val, series_value);
            errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated expected %0b actual %0b", e.sat, saturated);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_X_MIN: m_xmin = d;
      REG_INV_SPAN: m_span = d;
      REG_HARM_COUNT: m_hc = d[4:0];
      default: ;
    endcase
  endtask

  // valid stays high after the accepting edge; the next beat, an idle, a config write or drain replaces it
  task automatic send_beat(logic k, logic [4:0] ci, logic [31:0] cv, logic [31:0] xv);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1; kind <= k; coeff_index <= ci; coeff_value <= cv; x_value <= xv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k == KIND_LOAD) begin
      if (ci < 32) begin
        m_coef[ci] = cv;
      end
    end else begin
      series_q = {series_q, eval_series(xv)};
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (series_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_all(bit extreme);
    logic [31:0] v;
    for (int i = 0; i < 32; i++) begin
      v = extreme ? (($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000) : $urandom;
      if (!extreme && $urandom_range(1)) v = $signed(v) >>> $urandom_range(20);
      send_beat(KIND_LOAD, i[4:0], v, $urandom);
    end
  endtask

  task automatic test_directed();
    cfg_write(REG_X_MIN, 32'h0);
    cfg_write(REG_INV_SPAN, 32'h01000000);
    cfg_write(REG_HARM_COUNT, 32'd1);
    load_all(0);
    send_beat(KIND_EVAL, 5'd31, 32'hFFFFFFFF, 32'h0);
    send_beat(KIND_EVAL, 5'd0, 32'h0, 32'h7FFFFFFF);
    send_beat(KIND_EVAL, 5'd0, 32'h0, 32'h80000000);
    drain();
    cfg_write(REG_HARM_COUNT, 32'd0);
    send_beat(KIND_EVAL, 5'd0, 32'h0, 32'h00400000);
    drain();
    cfg_write(REG_HARM_COUNT, 32'd31);
    cfg_write(2'd3, 32'hFFFFFFFF);
    send_beat(KIND_EVAL, 5'd0, 32'h0, 32'h00400000);
    drain();
    cfg_write(REG_X_MIN, 32'h80000000);
    cfg_write(REG_INV_SPAN, 32'hFFFFFFFF);
    cfg_write(REG_HARM_COUNT, 32'd16);
    send_beat(KIND_EVAL, 5'd0, 32'h0, 32'h7FFFFFFF);
    drain();
    cfg_write(REG_X_MIN, 32'h7FFFFFFF);
    send_beat(KIND_EVAL, 5'd0, 32'h0, 32'h80000000);
    send_beat(KIND_EVAL, 5'd0, 32'h0, 32'h7FFFFFFF);
    drain();
    cfg_write(REG_INV_SPAN, 32'h0);
    load_all(1);
    send_beat(KIND_EVAL, 5'd0, 32'h0, 32'h12345678);
    drain();
  endtask

  task automatic test_random(int n);
    int rnd;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        drain();
        cfg_write(REG_X_MIN, $urandom_range(1) ? $urandom : $signed($urandom) >>> 8);
        cfg_write(REG_INV_SPAN, $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h04000000));
        cfg_write(REG_HARM_COUNT, $urandom_range(4) == 0 ? $urandom_range(31) : $urandom_range(5));
      end
      rnd = $urandom_range(99);
      if (rnd < 35)
        send_beat(KIND_LOAD, 5'($urandom),
                  $urandom_range(1) ? $urandom : $signed($urandom) >>> 12, $urandom);
      else
        send_beat(KIND_EVAL, 5'($urandom), $urandom,
                  $urandom_range(1) ? $urandom : m_xmin + ($signed($urandom) >>> 6));
    end
  endtask

  initial begin
    qtab = build_qtab();
    m_xmin = 0; m_span = 32'h01000000; m_hc = 5'd1;
    for (int i = 0; i < 32; i++) begin
      m_coef[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 0; recv_idle = 0;
    test_directed();
    send_idle = 35; recv_idle = 86;
    test_random(145);
    drain();
    send_idle = 86; recv_idle = 35;
    test_random(145);
    drain();
    send_idle = 0; recv_idle = 0;
    test_random(145);
    drain();
    if (errors == 0)
      $display("harmonic_series_eval_unit regression: pass");
    else
      $display("harmonic_series_eval_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
sv/hse_pkg.sv
sv/hse_ram.sv
sv/hse_ctrl.sv
sv/hse_dp.sv
sv/harmonic_series_eval_unit.sv
dv/tb_top.sv
